[design/dras_pkg.sv]
// ============================================================================
// dras_pkg
// Shared types and constants for the DNS response answer scanner.
// ============================================================================
package dras_pkg;

    // Parser phase while walking one packet.
    typedef enum logic [3:0] {
        PH_HDR    = 4'd0,
        PH_NLEN   = 4'd1,
        PH_NCHR   = 4'd2,
        PH_QTAIL  = 4'd3,
        PH_ASTART = 4'd4,
        PH_APTR   = 4'd5,
        PH_ALEN   = 4'd6,
        PH_ALBL   = 4'd7,
        PH_AFIX   = 4'd8,
        PH_ARDATA = 4'd9,
        PH_DONE   = 4'd10
    } phase_t;

    // Summary status codes.
    localparam logic [2:0] ST_CACHEABLE  = 3'd0;
    localparam logic [2:0] ST_BAD_HEADER = 3'd1;
    localparam logic [2:0] ST_BAD_NAME   = 3'd2;
    localparam logic [2:0] ST_NOT_IN_A   = 3'd3;
    localparam logic [2:0] ST_BAD_ANSWER = 3'd4;

    // Result kinds.
    localparam logic RK_NAME_CHAR = 1'b0;
    localparam logic RK_SUMMARY   = 1'b1;

    localparam logic [31:0] MAX_TTL_RESET   = 32'd86400;
    localparam logic [7:0]  MAX_LABEL_BYTES = 8'd63;
    localparam logic [7:0]  NAME_POINTER    = 8'hC0;
    localparam logic [15:0] CODE_IN_OR_A    = 16'h0001;
    localparam logic [7:0]  DOT_CHAR        = 8'h2E;
    localparam logic [15:0] RECORD_FIX_BYTES = 16'd10;
    localparam logic [15:0] QTAIL_BYTES     = 16'd4;

endpackage

[design/dns_response_answer_scanner_unit.sv]
// ============================================================================
// dns_response_answer_scanner_unit
// Byte-serial scanner that checks whether a DNS response can be cached.
// ============================================================================
// Usage: packet bytes enter on the input channel (in_valid / in_ready) with
// data_byte, the packet length and a last_byte flag. Each word updates the
// parser state in the cycle it is accepted; the question name characters
// and dots, and one summary on the last byte, leave through a single output
// register on the result channel (out_valid / out_ready).
// A result is shown in the cycle after its byte is accepted. Throughput
// is one byte per cycle, set by the byte-level parser update, while the
// receiver keeps up, and a new byte is taken in the same cycle the pending
// result is taken. When the receiver stalls, the result is held and
// in_ready drops only while a result waits and out_ready is low.
// Reset clears the parser to the header phase, empties the output register
// and sets max_ttl to 86400. The user writes max_ttl through cfg_write_enable
// and cfg_write_data only while the block is idle; the block does not enforce it.
// ============================================================================
module dns_response_answer_scanner_unit #(
    parameter int MAX_PACKET_BYTES = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_enable,
    input  logic [31:0] cfg_write_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic [12:0] packet_length,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        result_kind,
    output logic [7:0]  name_char,
    output logic [2:0]  scan_status,
    output logic [31:0] min_ttl,
    output logic [15:0] answer_count,
    output logic [12:0] answer_offset,
    output logic [12:0] answer_length,
    output logic [12:0] name_length
);

    localparam int POS_W = $clog2(MAX_PACKET_BYTES + 1);
    localparam int SUM_W = ((POS_W > 16) ? POS_W : 16) + 2;

    logic                  accept;

    logic [31:0]           max_ttl_reg;
    logic [POS_W-1:0]      pos_reg, pos_next;
    dras_pkg::phase_t      phase_reg, phase_next;
    logic [15:0]           fbl_reg, fbl_next;
    logic [31:0]           acc_reg, acc_next;
    logic [15:0]           hac_reg, hac_next;
    logic [15:0]           ans_left_reg, ans_left_next;
    logic [31:0]           rmin_reg, rmin_next;
    logic [POS_W-1:0]      ncc_reg, ncc_next;
    logic [POS_W-1:0]      astart_reg, astart_next;
    logic [POS_W-1:0]      aend_reg, aend_next;
    logic [2:0]            err_reg, err_next;

    logic                  out_valid_reg, out_valid_next;
    logic                  kind_reg, kind_next;
    logic [7:0]            char_reg, char_next;
    logic [2:0]            status_reg, status_next;
    logic [31:0]           mttl_reg, mttl_next;
    logic [15:0]           acount_reg, acount_next;
    logic [12:0]           aoff_reg, aoff_next;
    logic [12:0]           alen_reg, alen_next;
    logic [12:0]           nlen_reg, nlen_next;

    logic [SUM_W-1:0]      len_ext;
    logic [SUM_W-1:0]      pos_ext;
    logic [SUM_W-1:0]      pos_plus1;
    logic [SUM_W-1:0]      byte_ext;
    logic [31:0]           acc_shift;
    logic [15:0]           fbl_dec;
    logic [3:0]            fix_index;
    logic                  emit;
    logic [7:0]            ch;
    logic [2:0]            final_status;
    logic                  label_ok;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    assign len_ext   = (SUM_W'(packet_length) > SUM_W'(MAX_PACKET_BYTES))
                       ? SUM_W'(MAX_PACKET_BYTES) : SUM_W'(packet_length);
    assign pos_ext   = SUM_W'(pos_reg);
    assign pos_plus1 = pos_ext + SUM_W'(1);
    assign byte_ext  = SUM_W'(data_byte);
    assign acc_shift = {acc_reg[23:0], data_byte};
    assign fbl_dec   = fbl_reg - 16'd1;
    assign fix_index = 4'(dras_pkg::RECORD_FIX_BYTES - fbl_reg);

    // An answer label needs room for its bytes plus the fixed record header.
    assign label_ok = (data_byte <= dras_pkg::MAX_LABEL_BYTES) &&
                      !(pos_plus1 + byte_ext + SUM_W'(10) > len_ext);

    always_comb
    begin
        pos_next      = pos_reg;
        phase_next    = phase_reg;
        fbl_next      = fbl_reg;
        acc_next      = acc_reg;
        hac_next      = hac_reg;
        ans_left_next = ans_left_reg;
        rmin_next     = rmin_reg;
        ncc_next      = ncc_reg;
        astart_next   = astart_reg;
        aend_next     = aend_reg;
        err_next      = err_reg;
        emit          = 1'b0;
        ch            = 8'd0;
        final_status  = dras_pkg::ST_CACHEABLE;

        if (pos_ext < len_ext)
        begin
            case (phase_reg)
                dras_pkg::PH_HDR:
                begin
                    if (pos_ext == SUM_W'(2) && (!data_byte[7] || data_byte[1]))
                    begin
                        acc_next[31] = 1'b1;
                    end
                    if (pos_ext == SUM_W'(4) || pos_ext == SUM_W'(5))
                    begin
                        acc_next[15:0] = {acc_reg[7:0], data_byte};
                    end
                    if (pos_ext == SUM_W'(6) || pos_ext == SUM_W'(7))
                    begin
                        hac_next = {hac_reg[7:0], data_byte};
                    end
                    if (pos_ext == SUM_W'(11))
                    begin
                        if (acc_reg[31] || acc_reg[15:0] != 16'd1 || hac_reg == 16'd0)
                        begin
                            err_next   = dras_pkg::ST_BAD_HEADER;
                            phase_next = dras_pkg::PH_DONE;
                        end
                        else
                        begin
                            acc_next   = 32'd0;
                            phase_next = dras_pkg::PH_NLEN;
                        end
                    end
                end
                dras_pkg::PH_NLEN:
                begin
                    if (data_byte > dras_pkg::MAX_LABEL_BYTES ||
                        pos_plus1 + byte_ext + SUM_W'(4) > len_ext)
                    begin
                        err_next   = dras_pkg::ST_BAD_NAME;
                        phase_next = dras_pkg::PH_DONE;
                    end
                    else if (data_byte == 8'd0)
                    begin
                        fbl_next   = dras_pkg::QTAIL_BYTES;
                        acc_next   = 32'd0;
                        phase_next = dras_pkg::PH_QTAIL;
                    end
                    else
                    begin
                        if (ncc_reg != '0)
                        begin
                            emit     = 1'b1;
                            ch       = dras_pkg::DOT_CHAR;
                            ncc_next = ncc_reg + POS_W'(1);
                        end
                        fbl_next   = 16'(data_byte);
                        phase_next = dras_pkg::PH_NCHR;
                    end
                end
                dras_pkg::PH_NCHR:
                begin
                    ch       = (data_byte >= 8'h41 && data_byte <= 8'h5A)
                               ? data_byte + 8'h20 : data_byte;
                    emit     = 1'b1;
                    ncc_next = ncc_reg + POS_W'(1);
                    fbl_next = fbl_dec;
                    if (fbl_dec == 16'd0)
                    begin
                        phase_next = dras_pkg::PH_NLEN;
                    end
                end
                dras_pkg::PH_QTAIL:
                begin
                    acc_next = acc_shift;
                    fbl_next = fbl_dec;
                    if (fbl_dec == 16'd0)
                    begin
                        if (acc_shift[31:16] != dras_pkg::CODE_IN_OR_A ||
                            acc_shift[15:0] != dras_pkg::CODE_IN_OR_A)
                        begin
                            err_next   = dras_pkg::ST_NOT_IN_A;
                            phase_next = dras_pkg::PH_DONE;
                        end
                        else
                        begin
                            astart_next   = POS_W'(pos_plus1);
                            aend_next     = POS_W'(pos_plus1);
                            ans_left_next = hac_reg;
                            rmin_next     = max_ttl_reg;
                            if (hac_reg == 16'd0 || pos_plus1 >= len_ext)
                            begin
                                phase_next = dras_pkg::PH_DONE;
                            end
                            else
                            begin
                                phase_next = dras_pkg::PH_ASTART;
                            end
                        end
                    end
                end
                dras_pkg::PH_ASTART, dras_pkg::PH_ALEN:
                begin
                    if (phase_reg == dras_pkg::PH_ASTART)
                    begin
                        ans_left_next = ans_left_reg - 16'd1;
                    end
                    if (phase_reg == dras_pkg::PH_ASTART && data_byte == dras_pkg::NAME_POINTER)
                    begin
                        if (pos_ext + SUM_W'(12) > len_ext)
                        begin
                            err_next   = dras_pkg::ST_BAD_ANSWER;
                            phase_next = dras_pkg::PH_DONE;
                        end
                        else
                        begin
                            phase_next = dras_pkg::PH_APTR;
                        end
                    end
                    else if (!label_ok)
                    begin
                        err_next   = dras_pkg::ST_BAD_ANSWER;
                        phase_next = dras_pkg::PH_DONE;
                    end
                    else if (data_byte != 8'd0)
                    begin
                        fbl_next   = 16'(data_byte);
                        phase_next = dras_pkg::PH_ALBL;
                    end
                    else
                    begin
                        fbl_next   = dras_pkg::RECORD_FIX_BYTES;
                        acc_next   = 32'd0;
                        phase_next = dras_pkg::PH_AFIX;
                    end
                end
                dras_pkg::PH_APTR:
                begin
                    fbl_next   = dras_pkg::RECORD_FIX_BYTES;
                    acc_next   = 32'd0;
                    phase_next = dras_pkg::PH_AFIX;
                end
                dras_pkg::PH_ALBL:
                begin
                    fbl_next = fbl_dec;
                    if (fbl_dec == 16'd0)
                    begin
                        phase_next = dras_pkg::PH_ALEN;
                    end
                end
                dras_pkg::PH_AFIX:
                begin
                    acc_next = acc_shift;
                    fbl_next = fbl_dec;
                    if (fix_index == 4'd3 && acc_shift[15:0] != dras_pkg::CODE_IN_OR_A)
                    begin
                        err_next   = dras_pkg::ST_BAD_ANSWER;
                        phase_next = dras_pkg::PH_DONE;
                    end
                    else if (fix_index == 4'd7)
                    begin
                        if (acc_shift < rmin_reg)
                        begin
                            rmin_next = acc_shift;
                        end
                    end
                    else if (fix_index == 4'd9)
                    begin
                        if (pos_plus1 + SUM_W'(acc_shift[15:0]) > len_ext)
                        begin
                            err_next   = dras_pkg::ST_BAD_ANSWER;
                            phase_next = dras_pkg::PH_DONE;
                        end
                        else if (acc_shift[15:0] != 16'd0)
                        begin
                            fbl_next   = acc_shift[15:0];
                            phase_next = dras_pkg::PH_ARDATA;
                        end
                        else
                        begin
                            aend_next = POS_W'(pos_plus1);
                            if (ans_left_reg == 16'd0 || pos_plus1 >= len_ext)
                            begin
                                phase_next = dras_pkg::PH_DONE;
                            end
                            else
                            begin
                                phase_next = dras_pkg::PH_ASTART;
                            end
                        end
                    end
                end
                dras_pkg::PH_ARDATA:
                begin
                    fbl_next = fbl_dec;
                    if (fbl_dec == 16'd0)
                    begin
                        aend_next = POS_W'(pos_plus1);
                        if (ans_left_reg == 16'd0 || pos_plus1 >= len_ext)
                        begin
                            phase_next = dras_pkg::PH_DONE;
                        end
                        else
                        begin
                            phase_next = dras_pkg::PH_ASTART;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (pos_ext < SUM_W'(MAX_PACKET_BYTES))
        begin
            pos_next = pos_reg + POS_W'(1);
        end

        // An early end is classed by the phase the packet stopped in.
        final_status = err_next;
        if (err_next == dras_pkg::ST_CACHEABLE)
        begin
            if (phase_next == dras_pkg::PH_HDR)
            begin
                final_status = dras_pkg::ST_BAD_HEADER;
            end
            else if (phase_next inside {dras_pkg::PH_NLEN, dras_pkg::PH_NCHR,
                                        dras_pkg::PH_QTAIL})
            begin
                final_status = dras_pkg::ST_BAD_NAME;
            end
            else if (phase_next != dras_pkg::PH_ASTART && phase_next != dras_pkg::PH_DONE)
            begin
                final_status = dras_pkg::ST_BAD_ANSWER;
            end
        end

        kind_next   = dras_pkg::RK_NAME_CHAR;
        char_next   = ch;
        status_next = dras_pkg::ST_CACHEABLE;
        mttl_next   = 32'd0;
        acount_next = 16'd0;
        aoff_next   = 13'd0;
        alen_next   = 13'd0;
        nlen_next   = 13'd0;
        if (last_byte)
        begin
            kind_next   = dras_pkg::RK_SUMMARY;
            char_next   = 8'd0;
            status_next = final_status;
            mttl_next   = rmin_next;
            acount_next = hac_next;
            aoff_next   = 13'(astart_next);
            alen_next   = 13'(aend_next - astart_next);
            nlen_next   = 13'(ncc_next);

            pos_next      = '0;
            phase_next    = dras_pkg::PH_HDR;
            fbl_next      = 16'd0;
            acc_next      = 32'd0;
            hac_next      = 16'd0;
            ans_left_next = 16'd0;
            rmin_next     = max_ttl_reg;
            ncc_next      = '0;
            astart_next   = '0;
            aend_next     = '0;
            err_next      = dras_pkg::ST_CACHEABLE;
        end

        if (accept)
        begin
            out_valid_next = emit || last_byte;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_ttl_reg   <= dras_pkg::MAX_TTL_RESET;
            pos_reg       <= '0;
            phase_reg     <= dras_pkg::PH_HDR;
            fbl_reg       <= 16'd0;
            acc_reg       <= 32'd0;
            hac_reg       <= 16'd0;
            ans_left_reg  <= 16'd0;
            rmin_reg      <= dras_pkg::MAX_TTL_RESET;
            ncc_reg       <= '0;
            astart_reg    <= '0;
            aend_reg      <= '0;
            err_reg       <= dras_pkg::ST_CACHEABLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write_enable)
            begin
                max_ttl_reg <= cfg_write_data;
            end
            if (accept)
            begin
                pos_reg      <= pos_next;
                phase_reg    <= phase_next;
                fbl_reg      <= fbl_next;
                acc_reg      <= acc_next;
                hac_reg      <= hac_next;
                ans_left_reg <= ans_left_next;
                rmin_reg     <= rmin_next;
                ncc_reg      <= ncc_next;
                astart_reg   <= astart_next;
                aend_reg     <= aend_next;
                err_reg      <= err_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && (emit || last_byte))
        begin
            kind_reg   <= kind_next;
            char_reg   <= char_next;
            status_reg <= status_next;
            mttl_reg   <= mttl_next;
            acount_reg <= acount_next;
            aoff_reg   <= aoff_next;
            alen_reg   <= alen_next;
            nlen_reg   <= nlen_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign result_kind   = kind_reg;
    assign name_char     = char_reg;
    assign scan_status   = status_reg;
    assign min_ttl       = mttl_reg;
    assign answer_count  = acount_reg;
    assign answer_offset = aoff_reg;
    assign answer_length = alen_reg;
    assign name_length   = nlen_reg;

endmodule

[dv/tb.sv]
// ----------------------------------------------------------------------------
// tb: testbench for dns_response_answer_scanner_unit
// Streams DNS response packets into the scanner a byte at a time, mostly
// well-formed responses with random content and some broken or random ones.
// A predictor in the testbench works out the name characters and the summary
// for each packet, and every result word is checked field by field.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          PKT_MAX     = 4096;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned SEG_WORDS   = 225;

    typedef struct packed {
        logic [7:0]  data;
        logic [12:0] plen;
        logic        lastb;
    } packet_word_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  ch;
        logic [2:0]  status;
        logic [31:0] ttl;
        logic [15:0] ancount;
        logic [12:0] offset;
        logic [12:0] span;
        logic [12:0] name_len;
    } scan_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_write_enable = 1'b0;
    logic [31:0] cfg_write_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  data_byte = '0;
    logic [12:0] packet_length = '0;
    logic        last_byte = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        result_kind;
    logic [7:0]  name_char;
    logic [2:0]  scan_status;
    logic [31:0] min_ttl;
    logic [15:0] answer_count;
    logic [12:0] answer_offset;
    logic [12:0] answer_length;
    logic [12:0] name_length;

    packet_word_t packet_words[$];
    scan_result_t scan_results_due[$];
    logic [7:0]   pkt[$];
    int unsigned  qtail_at;
    int unsigned  ans_at;
    int unsigned  send_idle_pct = 0;
    int unsigned  recv_idle_pct = 0;
    int unsigned  error_count = 0;
    int unsigned  results_checked = 0;
    int unsigned  hold_left = 0;
    bit           hold_done = 1'b0;

    // Predictor state.
    int unsigned       m_max_ttl;
    int unsigned       m_pos;
    dras_pkg::phase_t  m_phase;
    int unsigned       m_left;
    int unsigned       m_acc;
    int unsigned       m_ancount;
    int unsigned       m_ans_left;
    int unsigned       m_min_ttl;
    int unsigned       m_name_len;
    int unsigned       m_ans_start;
    int unsigned       m_ans_end;
    logic [2:0]        m_err;

    dns_response_answer_scanner_unit #(
        .MAX_PACKET_BYTES(PKT_MAX)
    ) u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_enable (cfg_write_enable),
        .cfg_write_data   (cfg_write_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .data_byte        (data_byte),
        .packet_length    (packet_length),
        .last_byte        (last_byte),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .result_kind      (result_kind),
        .name_char        (name_char),
        .scan_status      (scan_status),
        .min_ttl          (min_ttl),
        .answer_count     (answer_count),
        .answer_offset    (answer_offset),
        .answer_length    (answer_length),
        .name_length      (name_length)
    );

    always #5 clk = ~clk;

    function automatic void restart_packet();
        m_pos       = 0;
        m_phase     = dras_pkg::PH_HDR;
        m_left      = 0;
        m_acc       = 0;
        m_ancount   = 0;
        m_ans_left  = 0;
        m_min_ttl   = m_max_ttl;
        m_name_len  = 0;
        m_ans_start = 0;
        m_ans_end   = 0;
        m_err       = dras_pkg::ST_CACHEABLE;
    endfunction

    function automatic void abort_scan(logic [2:0] code);
        m_err   = code;
        m_phase = dras_pkg::PH_DONE;
    endfunction

    function automatic void close_record(int unsigned p, int unsigned len);
        m_ans_end = p + 1;
        m_phase   = (m_ans_left == 0 || p + 1 >= len) ? dras_pkg::PH_DONE
                                                      : dras_pkg::PH_ASTART;
    endfunction

    function automatic void answer_label(int unsigned p, int unsigned q, int unsigned len);
        if (q > dras_pkg::MAX_LABEL_BYTES || p + 1 + q + dras_pkg::RECORD_FIX_BYTES > len)
        begin
            abort_scan(dras_pkg::ST_BAD_ANSWER);
        end
        else if (q > 0)
        begin
            m_left  = q;
            m_phase = dras_pkg::PH_ALBL;
        end
        else
        begin
            m_left  = 32'(dras_pkg::RECORD_FIX_BYTES);
            m_acc   = 0;
            m_phase = dras_pkg::PH_AFIX;
        end
    endfunction

    // Advances the predicted parser by one packet byte; returns 1 when the
    // byte produces a result word.
    function automatic bit scan_byte(input logic [7:0] b, input logic [12:0] plen,
                                     input logic lastb, output scan_result_t r);
        int unsigned len;
        int unsigned p;
        int unsigned k;
        int unsigned rdlen;
        bit          emit;
        logic [7:0]  ch;
        logic [2:0]  st;
        len  = (32'(plen) > PKT_MAX) ? PKT_MAX : 32'(plen);
        p    = m_pos;
        emit = 1'b0;
        ch   = '0;
        r    = '0;
        if (p < len)
        begin
            case (m_phase)
                dras_pkg::PH_HDR:
                begin
                    if (p == 2 && (b[7] == 1'b0 || b[1] == 1'b1))
                        m_acc = m_acc | 32'h8000_0000;
                    if (p == 4 || p == 5)
                        m_acc = (m_acc & 32'hFFFF_0000) | (((m_acc << 8) | b) & 32'hFFFF);
                    if (p == 6 || p == 7)
                        m_ancount = ((m_ancount << 8) | b) & 32'hFFFF;
                    if (p == 11)
                    begin
                        if (m_acc[31] || (m_acc & 32'hFFFF) != 1 || m_ancount == 0)
                            abort_scan(dras_pkg::ST_BAD_HEADER);
                        else
                        begin
                            m_acc   = 0;
                            m_phase = dras_pkg::PH_NLEN;
                        end
                    end
                end
                dras_pkg::PH_NLEN:
                begin
                    if (b > dras_pkg::MAX_LABEL_BYTES || p + 1 + b + dras_pkg::QTAIL_BYTES > len)
                        abort_scan(dras_pkg::ST_BAD_NAME);
                    else if (b == 0)
                    begin
                        m_left  = 32'(dras_pkg::QTAIL_BYTES);
                        m_acc   = 0;
                        m_phase = dras_pkg::PH_QTAIL;
                    end
                    else
                    begin
                        // A dot goes out before every label but the first.
                        if (m_name_len > 0)
                        begin
                            emit = 1'b1;
                            ch   = dras_pkg::DOT_CHAR;
                            m_name_len++;
                        end
                        m_left  = 32'(b);
                        m_phase = dras_pkg::PH_NCHR;
                    end
                end
                dras_pkg::PH_NCHR:
                begin
                    ch   = (b >= 8'h41 && b <= 8'h5A) ? b + 8'h20 : b;
                    emit = 1'b1;
                    m_name_len++;
                    m_left--;
                    if (m_left == 0)
                        m_phase = dras_pkg::PH_NLEN;
                end
                dras_pkg::PH_QTAIL:
                begin
                    m_acc = (m_acc << 8) | b;
                    m_left--;
                    if (m_left == 0)
                    begin
                        if ((m_acc >> 16) != dras_pkg::CODE_IN_OR_A ||
                            (m_acc & 32'hFFFF) != dras_pkg::CODE_IN_OR_A)
                            abort_scan(dras_pkg::ST_NOT_IN_A);
                        else
                        begin
                            m_ans_start = p + 1;
                            m_ans_end   = p + 1;
                            m_ans_left  = m_ancount;
                            m_min_ttl   = m_max_ttl;
                            m_phase     = (m_ans_left == 0 || p + 1 >= len)
                                          ? dras_pkg::PH_DONE : dras_pkg::PH_ASTART;
                        end
                    end
                end
                dras_pkg::PH_ASTART:
                begin
                    m_ans_left--;
                    if (b == dras_pkg::NAME_POINTER)
                    begin
                        if (p + 2 + dras_pkg::RECORD_FIX_BYTES > len)
                            abort_scan(dras_pkg::ST_BAD_ANSWER);
                        else
                            m_phase = dras_pkg::PH_APTR;
                    end
                    else
                        answer_label(p, 32'(b), len);
                end
                dras_pkg::PH_APTR:
                begin
                    m_left  = 32'(dras_pkg::RECORD_FIX_BYTES);
                    m_acc   = 0;
                    m_phase = dras_pkg::PH_AFIX;
                end
                dras_pkg::PH_ALEN:
                    answer_label(p, 32'(b), len);
                dras_pkg::PH_ALBL:
                begin
                    m_left--;
                    if (m_left == 0)
                        m_phase = dras_pkg::PH_ALEN;
                end
                dras_pkg::PH_AFIX:
                begin
                    // k counts the record header bytes seen before this one.
                    k     = 32'(dras_pkg::RECORD_FIX_BYTES) - m_left;
                    m_acc = (m_acc << 8) | b;
                    m_left--;
                    if (k == 3 && (m_acc & 32'hFFFF) != dras_pkg::CODE_IN_OR_A)
                        abort_scan(dras_pkg::ST_BAD_ANSWER);
                    else if (k == 7)
                    begin
                        if (m_acc < m_min_ttl)
                            m_min_ttl = m_acc;
                    end
                    else if (k == 9)
                    begin
                        rdlen = m_acc & 32'hFFFF;
                        if (p + 1 + rdlen > len)
                            abort_scan(dras_pkg::ST_BAD_ANSWER);
                        else if (rdlen > 0)
                        begin
                            m_left  = rdlen;
                            m_phase = dras_pkg::PH_ARDATA;
                        end
                        else
                            close_record(p, len);
                    end
                end
                dras_pkg::PH_ARDATA:
                begin
                    m_left--;
                    if (m_left == 0)
                        close_record(p, len);
                end
                default: ;
            endcase
        end

        if (m_pos < PKT_MAX)
            m_pos++;

        if (lastb)
        begin
            st = m_err;
            if (st == dras_pkg::ST_CACHEABLE)
            begin
                if (m_phase == dras_pkg::PH_HDR)
                    st = dras_pkg::ST_BAD_HEADER;
                else if (m_phase == dras_pkg::PH_NLEN || m_phase == dras_pkg::PH_NCHR ||
                         m_phase == dras_pkg::PH_QTAIL)
                    st = dras_pkg::ST_BAD_NAME;
                else if (m_phase != dras_pkg::PH_ASTART && m_phase != dras_pkg::PH_DONE)
                    st = dras_pkg::ST_BAD_ANSWER;
            end
            r.kind     = dras_pkg::RK_SUMMARY;
            r.status   = st;
            r.ttl      = m_min_ttl;
            r.ancount  = 16'(m_ancount);
            r.offset   = 13'(m_ans_start);
            r.span     = 13'(m_ans_end - m_ans_start);
            r.name_len = 13'(m_name_len);
            restart_packet();
            return 1'b1;
        end
        if (emit)
        begin
            r.kind = dras_pkg::RK_NAME_CHAR;
            r.ch   = ch;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
            error_count++;
        end
    endfunction

    function automatic void put16(int unsigned v);
        pkt.push_back(v[15:8]);
        pkt.push_back(v[7:0]);
    endfunction

    // Builds a well-formed response with random content into pkt.
    function automatic void build_response();
        logic [15:0] flags;
        logic [31:0] ttl;
        int unsigned nans;
        int unsigned nrec;
        int unsigned nlab;
        int unsigned lablen;
        int unsigned rdlen;
        pkt.delete();
        put16($urandom);
        flags = 16'($urandom);
        // Response bit set, truncation bit clear, the other flags free.
        pkt.push_back({1'b1, flags[6:2], 1'b0, flags[0]});
        pkt.push_back(flags[15:8]);
        put16(1);
        nans = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 65535) : $urandom_range(1, 4);
        put16(nans);
        put16($urandom_range(0, 2));
        put16($urandom_range(0, 2));
        nlab = $urandom_range(0, 4);
        for (int i = 0; i < nlab; i++)
        begin
            lablen = ($urandom_range(0, 29) == 0) ? 32'(dras_pkg::MAX_LABEL_BYTES)
                                                  : $urandom_range(1, 8);
            pkt.push_back(8'(lablen));
            for (int j = 0; j < lablen; j++)
            begin
                case ($urandom_range(0, 3))
                    0:       pkt.push_back(8'(32'h41 + $urandom_range(0, 25)));
                    1:       pkt.push_back(8'(32'h61 + $urandom_range(0, 25)));
                    2:       pkt.push_back(8'(32'h30 + $urandom_range(0, 9)));
                    default: pkt.push_back(8'($urandom));
                endcase
            end
        end
        pkt.push_back(8'h00);
        qtail_at = pkt.size();
        put16(32'(dras_pkg::CODE_IN_OR_A));
        put16(32'(dras_pkg::CODE_IN_OR_A));
        ans_at = pkt.size();
        // With a large answer count the packet simply ends after a few records.
        nrec = (nans > 4) ? $urandom_range(1, 4) : nans;
        if (nrec > 1 && $urandom_range(0, 9) == 0)
            nrec--;
        for (int i = 0; i < nrec; i++)
        begin
            if ($urandom_range(0, 2) != 0)
            begin
                pkt.push_back(dras_pkg::NAME_POINTER);
                pkt.push_back(8'($urandom));
            end
            else
            begin
                nlab = $urandom_range(0, 2);
                for (int j = 0; j < nlab; j++)
                begin
                    lablen = $urandom_range(1, 5);
                    pkt.push_back(8'(lablen));
                    repeat (lablen) pkt.push_back(8'($urandom));
                end
                pkt.push_back(8'h00);
            end
            put16(($urandom_range(0, 3) == 0) ? $urandom : 32'd1);
            put16(32'(dras_pkg::CODE_IN_OR_A));
            case ($urandom_range(0, 4))
                0:       ttl = 32'd0;
                1:       ttl = $urandom_range(1, 600);
                2:       ttl = 32'd86399 + $urandom_range(0, 2);
                3:       ttl = 32'hFFFF_FFFF;
                default: ttl = $urandom;
            endcase
            put16(32'(ttl[31:16]));
            put16(32'(ttl[15:0]));
            rdlen = $urandom_range(0, 6);
            put16(rdlen);
            repeat (rdlen) pkt.push_back(8'($urandom));
        end
    endfunction

    // Waits until every queued word is taken and every result has arrived.
    task automatic settle();
        while (packet_words.size() != 0 || in_valid || scan_results_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_max_ttl(logic [31:0] v);
        @(posedge clk);
        cfg_write_enable <= 1'b1;
        cfg_write_data   <= v;
        @(posedge clk);
        cfg_write_enable <= 1'b0;
    endtask

    task automatic queue_packet(logic [12:0] plen, int unsigned pause_at);
        packet_word_t w;
        for (int i = 0; i < pkt.size(); i++)
        begin
            if (pause_at != 0 && i == pause_at)
                settle();
            w.data  = pkt[i];
            w.plen  = plen;
            w.lastb = (i == pkt.size() - 1);
            packet_words.push_back(w);
        end
    endtask

    always @(posedge clk)
    begin
        packet_word_t w;
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || in_ready)
        begin
            if (packet_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                w = packet_words.pop_front();
                in_valid      <= 1'b1;
                data_byte     <= w.data;
                packet_length <= w.plen;
                last_byte     <= w.lastb;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Receiver, with one long hold-off once traffic is flowing so that the
    // output register fills and the input stalls.
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_left != 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (!hold_done && results_checked >= 100)
        begin
            hold_done <= 1'b1;
            hold_left <= 400;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        scan_result_t r;
        scan_result_t want;
        if (!rst_n)
        begin
            m_max_ttl = dras_pkg::MAX_TTL_RESET;
            restart_packet();
        end
        else
        begin
            if (cfg_write_enable)
                m_max_ttl = cfg_write_data;
            if (in_valid && in_ready)
            begin
                if (scan_byte(data_byte, packet_length, last_byte, r))
                    scan_results_due.push_back(r);
            end
            if (out_valid && out_ready)
            begin
                if (scan_results_due.size() == 0)
                begin
                    $error("result word with nothing expected");
                    error_count++;
                end
                else
                begin
                    want = scan_results_due.pop_front();
                    check_field("result_kind", 32'(want.kind), 32'(result_kind));
                    check_field("name_char", 32'(want.ch), 32'(name_char));
                    check_field("scan_status", 32'(want.status), 32'(scan_status));
                    check_field("min_ttl", want.ttl, min_ttl);
                    check_field("answer_count", 32'(want.ancount), 32'(answer_count));
                    check_field("answer_offset", 32'(want.offset), 32'(answer_offset));
                    check_field("answer_length", 32'(want.span), 32'(answer_length));
                    check_field("name_length", 32'(want.name_len), 32'(name_length));
                end
                results_checked++;
            end
        end
    end

    initial
    begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("tb: errors");
        $finish;
    end

    initial
    begin
        logic [12:0] plen;
        logic [31:0] ttl_setting;
        int unsigned seg_words;
        int unsigned cut;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // A lone byte beyond a zero packet length, then a minimal cacheable
        // response with an upper-case name, a root-named answer and the
        // largest TTL, all under the reset value of max_ttl.
        pkt = '{8'hFF};
        queue_packet(13'd0, 0);
        pkt = '{8'hFF, 8'hFF, 8'hFD, 8'hFF, 8'h00, 8'h01, 8'h00, 8'h01, 8'hFF, 8'hFF,
                8'hFF, 8'hFF, 8'h01, 8'h5A, 8'h00, 8'h00, 8'h01, 8'h00, 8'h01, 8'h00,
                8'h00, 8'hFF, 8'h00, 8'h01, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00};
        queue_packet(13'd30, 0);

        for (int seg = 0; seg < 6; seg++)
        begin
            settle();
            send_idle_pct = (seg < 2) ? 15 : (seg < 4) ? 85 : 0;
            recv_idle_pct = (seg < 2) ? 85 : (seg < 4) ? 15 : 0;
            case (seg)
                0:       ttl_setting = 32'd0;
                1:       ttl_setting = 32'hFFFF_FFFF;
                2:       ttl_setting = 32'd300;
                3:       ttl_setting = $urandom;
                4:       ttl_setting = 32'd1;
                default: ttl_setting = dras_pkg::MAX_TTL_RESET;
            endcase
            write_max_ttl(ttl_setting);
            seg_words = 0;
            while (seg_words < SEG_WORDS)
            begin
                build_response();
                plen = 13'(pkt.size());
                if ($urandom_range(0, 9) < 4)
                begin
                    case ($urandom_range(0, 8))
                        0: pkt[$urandom_range(0, pkt.size() - 1)] = 8'($urandom);
                        1:
                        begin
                            // Early end: the length still claims the full packet.
                            cut = $urandom_range(1, pkt.size());
                            while (pkt.size() > cut)
                                void'(pkt.pop_back());
                        end
                        2: plen = 13'($urandom_range(0, 8191));
                        3: plen = 13'(pkt.size() + $urandom_range(1, 20));
                        4:
                        begin
                            case ($urandom_range(0, 3))
                                0: pkt[2] = pkt[2] & 8'h7F;
                                1: pkt[2] = pkt[2] | 8'h02;
                                2:
                                begin
                                    pkt[4] = 8'($urandom);
                                    pkt[5] = 8'($urandom);
                                end
                                default:
                                begin
                                    pkt[6] = 8'h00;
                                    pkt[7] = 8'h00;
                                end
                            endcase
                        end
                        5: pkt[qtail_at + $urandom_range(0, 3)] = 8'($urandom);
                        6: pkt[$urandom_range(ans_at, pkt.size() - 1)] = 8'($urandom);
                        7:
                        begin
                            pkt.delete();
                            repeat ($urandom_range(1, 40)) pkt.push_back(8'($urandom));
                            plen = $urandom_range(0, 1) ? 13'(pkt.size())
                                                        : 13'($urandom_range(0, 8191));
                        end
                        default:
                        begin
                            repeat ($urandom_range(1, 8)) pkt.push_back(8'($urandom));
                            plen = 13'(pkt.size());
                        end
                    endcase
                end
                // Once, the sender stops half-way through a packet until the
                // block has handed over everything it owes.
                queue_packet(plen, (seg == 1 && seg_words == 0) ? pkt.size() / 2 : 0);
                seg_words += pkt.size();
            end
        end
        settle();
        if (error_count == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

[dns_response_answer_scanner_unit.f]
design/dras_pkg.sv
design/dns_response_answer_scanner_unit.sv
dv/tb.sv
